FILE: src/sorted_region_table_merge_assert.svh
// Assertion macros used by the region table top level.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef SORTED_REGION_TABLE_MERGE_ASSERT_SVH
`define SORTED_REGION_TABLE_MERGE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SRTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/srtm_pkg.sv
// Package for the sorted region table: request and response types, codes,
// the per-entry record, cell control record and type classification.
package srtm_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int CLASS_COUNT   = 4;
  localparam int IDX_W         = 11;
  localparam logic [6:0]  RANK_MAX = 7'd127;
  localparam logic [31:0] ADDR_MAX = 32'hffff_ffff;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_HIGH    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_RANGE   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MERGE,
    S_CLASS,
    S_DELIVER
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_MERGE,
    OP_RANK
  } cell_op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] base;
    logic [63:0] length;
    logic [31:0] region_type;
    logic [6:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] entry_start;
    logic [31:0] entry_end;
    logic [31:0] entry_type;
    logic [1:0]  entry_class;
    logic [6:0]  class_rank;
    logic [7:0]  entry_count;
  } out_t;

  typedef struct packed {
    logic [31:0] region_start;
    logic [31:0] region_end;
    logic [31:0] region_kind;
    logic [6:0]  region_rank;
  } entry_t;

  typedef struct packed {
    cell_op_t         op;
    entry_t           fresh;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] count;
    logic [IDX_W-1:0] pick;
  } cell_ctrl_t;

  function automatic logic kind_known(input logic [31:0] kind);
    return (kind >= 32'd1) && (kind <= 32'(CLASS_COUNT));
  endfunction

  function automatic logic [1:0] kind_class(input logic [31:0] kind);
    logic [31:0] k;
    k = kind - 32'd1;
    return k[1:0];
  endfunction

endpackage

FILE: src/srtm_cell.sv
// One table cell: holds one region entry and moves it to or from its
// neighbors on insert and merge. Depends on srtm_pkg.
module srtm_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  srtm_pkg::cell_ctrl_t ctrl,
  input  srtm_pkg::entry_t   left,
  input  srtm_pkg::entry_t   right,
  input  logic               le_left,
  output srtm_pkg::entry_t   ent,
  output logic               le,
  output logic               hit,
  output srtm_pkg::entry_t   tap
);
  import srtm_pkg::*;

  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  // Sorted starts make le a prefix over the occupied cells.
  assign le  = (ME < ctrl.count) && (ent.region_start <= ctrl.fresh.region_start);
  assign hit = (ME == ctrl.pos) && (ent.region_start <= right.region_start) &&
               (ent.region_end >= right.region_start) &&
               (ent.region_kind == right.region_kind);
  assign tap = (ME == ctrl.pick) ? ent : '0;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (ME <= ctrl.count && !le) begin
          ent <= le_left ? ctrl.fresh : left;
        end
      end
      OP_MERGE: begin
        if (ME == ctrl.pos) begin
          if (right.region_end > ent.region_end) begin
            ent.region_end <= right.region_end;
          end
        end else if (ME > ctrl.pos) begin
          ent <= right;
        end
      end
      OP_RANK: begin
        if (ME == ctrl.pos) begin
          ent.region_rank <= ctrl.fresh.region_rank;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: src/sorted_region_table_merge.sv
// Sorted region table top level: control state machine over a chain of srtm_cell entries.
// Depends on srtm_pkg, srtm_cell and sorted_region_table_merge_assert.svh.
// Insert, read and the undefined command go from idle straight to the deliver state; merge
// passes through the merge and classify states first. The response is loaded on deliver.
// No new request is taken until the response is loaded and the state is idle again; a stalled
// response holds the block busy. Reset empties the table by clearing the count; cells keep data.
module sorted_region_table_merge #(
  parameter int TABLE_DEPTH = srtm_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  srtm_pkg::in_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output srtm_pkg::out_t out_rsp
);
  import srtm_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t      state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  out_t        res;
  out_t        idle_res;
  out_t        rsp_final;
  logic [6:0]  next_rank [CLASS_COUNT];

  cell_ctrl_t  ctrl;
  entry_t      ents [TABLE_DEPTH];
  entry_t      taps [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] les;
  logic [TABLE_DEPTH-1:0] hits;
  entry_t      picked;

  logic        accept;
  logic        more_pairs;
  logic        merge_hit;
  logic        in_class;
  logic        out_free;
  logic [31:0] ins_end;
  logic [CW:0] ptr_plus;

  // The chain of cells. Each cell sees its neighbors only.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    entry_t lft, rgt;
    logic   lel;
    if (i == 0) begin : g_first
      assign lft = '0;
      assign lel = 1'b1;
    end else begin : g_mid
      assign lft = ents[i-1];
      assign lel = les[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_inner
      assign rgt = ents[i+1];
    end
    srtm_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left    (lft),
      .right   (rgt),
      .le_left (lel),
      .ent     (ents[i]),
      .le      (les[i]),
      .hit     (hits[i]),
      .tap     (taps[i])
    );
  end

  // Only the addressed cell drives a nonzero tap, so an OR collects it.
  always_comb begin
    picked = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      picked = picked | taps[i];
    end
  end

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state != S_IDLE);
  assign ptr_plus   = {1'b0, ptr} + {{CW{1'b0}}, 1'b1};
  assign more_pairs = ptr_plus < {1'b0, count};
  assign merge_hit  = |hits;
  assign in_class   = ptr < count;
  assign out_free   = !out_valid || !out_stall;

  // End address of an inserted region, clamped to the top of the 4G space.
  always_comb begin
    if (in_req.length[63:32] != 32'd0 ||
        in_req.length[31:0] >= (ADDR_MAX - in_req.base[31:0])) begin
      ins_end = ADDR_MAX;
    end else begin
      ins_end = in_req.base[31:0] + in_req.length[31:0];
    end
  end

  // Response of a request taken in the idle state. Merge starts from an OK status.
  always_comb begin
    idle_res = '0;
    case (cmd_t'(in_req.command))
      CMD_INSERT: begin
        if (in_req.base[63:32] != 32'd0) begin
          idle_res.status = ST_HIGH;
        end else if (count == CW'(TABLE_DEPTH)) begin
          idle_res.status = ST_FULL;
        end
      end
      CMD_READ: begin
        if (32'(in_req.read_index) >= 32'(count) ||
            32'(in_req.read_index) >= 32'(TABLE_DEPTH)) begin
          idle_res.status = ST_RANGE;
        end else begin
          idle_res.entry_start = picked.region_start;
          idle_res.entry_end   = picked.region_end;
          idle_res.entry_type  = picked.region_kind;
          idle_res.class_rank  = picked.region_rank;
          if (kind_known(picked.region_kind)) begin
            idle_res.entry_class = kind_class(picked.region_kind);
          end else begin
            idle_res.status = ST_UNKNOWN;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The entry count is taken once the request has finished changing the table.
  always_comb begin
    rsp_final = res;
    rsp_final.entry_count = 8'(count);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd_t'(in_req.command) == CMD_MERGE) ? S_MERGE : S_DELIVER;
        end
      end
      S_MERGE: begin
        if (!more_pairs) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        if (!in_class) begin
          state_next = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the cell chain.
  always_comb begin
    ctrl       = '0;
    ctrl.op    = OP_HOLD;
    ctrl.count = IDX_W'(count);
    ctrl.pos   = IDX_W'(ptr);
    ctrl.pick  = IDX_W'(ptr);
    case (state)
      S_IDLE: begin
        ctrl.pick = IDX_W'(in_req.read_index);
        ctrl.fresh.region_start = in_req.base[31:0];
        ctrl.fresh.region_end   = ins_end;
        ctrl.fresh.region_kind  = in_req.region_type;
        ctrl.fresh.region_rank  = 7'd0;
        if (accept && cmd_t'(in_req.command) == CMD_INSERT &&
            in_req.base[63:32] == 32'd0 && count != CW'(TABLE_DEPTH)) begin
          ctrl.op = OP_INSERT;
        end
      end
      S_MERGE: begin
        if (more_pairs && merge_hit) begin
          ctrl.op = OP_MERGE;
        end
      end
      S_CLASS: begin
        if (in_class) begin
          ctrl.op = OP_RANK;
          ctrl.fresh.region_rank = kind_known(picked.region_kind) ?
                                   next_rank[kind_class(picked.region_kind)] : 7'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DELIVER && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            res <= idle_res;
            ptr <= '0;
            if (cmd_t'(in_req.command) == CMD_INSERT && in_req.base[63:32] == 32'd0 &&
                count != CW'(TABLE_DEPTH)) begin
              count <= count + CW'(1);
            end
          end
        end
        S_MERGE: begin
          if (more_pairs) begin
            if (merge_hit) begin
              count <= count - CW'(1);
            end else begin
              ptr <= ptr + CW'(1);
            end
          end else begin
            ptr <= '0;
            for (int c = 0; c < CLASS_COUNT; c++) begin
              next_rank[c] <= 7'd0;
            end
          end
        end
        S_CLASS: begin
          if (in_class) begin
            ptr <= ptr + CW'(1);
            if (kind_known(picked.region_kind)) begin
              if (next_rank[kind_class(picked.region_kind)] < RANK_MAX) begin
                next_rank[kind_class(picked.region_kind)] <=
                  next_rank[kind_class(picked.region_kind)] + 7'd1;
              end
            end else begin
              res.status <= ST_UNKNOWN;
            end
          end
        end
        S_DELIVER: begin
          if (out_free) begin
            out_rsp <= rsp_final;
          end
        end
        default: begin
        end
      endcase
    end
  end

`include "sorted_region_table_merge_assert.svh"

  `SRTM_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH), "table count above depth")
  `SRTM_ASSERT_NEXT(a_merge_shrinks, state == S_MERGE, count <= $past(count), "merge grew the table")
  `SRTM_ASSERT_NOW(a_class_ptr, state == S_CLASS, ptr <= count, "classify pointer past the table")
  `SRTM_ASSERT_NEXT(a_deliver_sets, state == S_DELIVER && out_free, out_valid, "response lost")

endmodule

FILE: bench/region_table_checker.sv
// Checker for the sorted region table: predicts every response from the requests it sees.
// Needs srtm_pkg for the request and response types and the command and status codes.
`timescale 1ns / 100ps

module region_table_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  srtm_pkg::in_t  in_req,
  input  logic           out_valid,
  input  logic           out_stall,
  input  srtm_pkg::out_t out_rsp,
  output int             errors,
  output int             pending
);
  import srtm_pkg::*;

  localparam int ROWS = DEPTH_DEFAULT;

  logic [31:0] row_start [ROWS];
  logic [31:0] row_end [ROWS];
  logic [31:0] row_kind [ROWS];
  logic [6:0]  row_rank [ROWS];
  int          row_count;
  out_t        rsp_queue [$];

  assign pending = rsp_queue.size();

  function automatic int class_code(input logic [31:0] kind);
    if (kind >= 32'd1 && kind <= 32'(CLASS_COUNT)) return int'(kind) - 1;
    return -1;
  endfunction

  function automatic void shift_row(input int dst, input int src);
    row_start[dst] = row_start[src];
    row_end[dst]   = row_end[src];
    row_kind[dst]  = row_kind[src];
    row_rank[dst]  = row_rank[src];
  endfunction

  function automatic out_t table_update(input in_t r);
    out_t        rsp;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] len_lo;
    int          pos;
    int          c;
    int          idx;
    int          next_rank [CLASS_COUNT];
    rsp = '0;
    case (cmd_t'(r.command))
      CMD_INSERT: begin
        if (r.base[63:32] != 0) begin
          rsp.status = ST_HIGH;
        end else if (row_count >= ROWS) begin
          rsp.status = ST_FULL;
        end else begin
          lo = r.base[31:0];
          len_lo = r.length[31:0];
          if (r.length[63:32] != 0 || len_lo >= ADDR_MAX - lo) hi = ADDR_MAX;
          else hi = lo + len_lo;
          pos = 0;
          while (pos < row_count && row_start[pos] <= lo) pos++;
          for (int i = row_count; i > pos; i--) shift_row(i, i - 1);
          row_start[pos] = lo;
          row_end[pos]   = hi;
          row_kind[pos]  = r.region_type;
          row_rank[pos]  = '0;
          row_count++;
          rsp.status = ST_OK;
        end
      end
      CMD_MERGE: begin
        rsp.status = ST_OK;
        idx = 0;
        // Whole chains of overlapping same-type neighbors fold into one entry.
        while (idx + 1 < row_count) begin
          if (row_start[idx] <= row_start[idx+1] && row_end[idx] >= row_start[idx+1] &&
              row_kind[idx] == row_kind[idx+1]) begin
            if (row_end[idx+1] > row_end[idx]) row_end[idx] = row_end[idx+1];
            for (int j = idx + 1; j + 1 < row_count; j++) shift_row(j, j + 1);
            row_count--;
          end else begin
            idx++;
          end
        end
        for (int k = 0; k < CLASS_COUNT; k++) next_rank[k] = 0;
        for (int i = 0; i < row_count; i++) begin
          c = class_code(row_kind[i]);
          if (c < 0) begin
            row_rank[i] = '0;
            rsp.status = ST_UNKNOWN;
          end else begin
            row_rank[i] = 7'(next_rank[c]);
            if (next_rank[c] < int'(RANK_MAX)) next_rank[c]++;
          end
        end
      end
      CMD_READ: begin
        idx = int'(r.read_index);
        if (idx >= row_count) begin
          rsp.status = ST_RANGE;
        end else begin
          c = class_code(row_kind[idx]);
          rsp.entry_start = row_start[idx];
          rsp.entry_end   = row_end[idx];
          rsp.entry_type  = row_kind[idx];
          rsp.entry_class = (c < 0) ? 2'd0 : 2'(c);
          rsp.class_rank  = row_rank[idx];
          rsp.status      = (c < 0) ? ST_UNKNOWN : ST_OK;
        end
      end
      default: rsp.status = ST_OK;
    endcase
    rsp.entry_count = 8'(row_count);
    return rsp;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      row_count = 0;
      rsp_queue.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: response with none expected: %p", $time, out_rsp);
          errors++;
        end else begin
          want = rsp_queue.pop_front();
          if (want !== out_rsp) begin
            $display("%0t: response mismatch: expected %p, actual %p", $time, want, out_rsp);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) rsp_queue.push_back(table_update(in_req));
    end
  end
endmodule

FILE: bench/tb.sv
// Top of the region table bench: clock, reset, request stimulus and the final verdict.
// Needs srtm_pkg, sorted_region_table_merge and region_table_checker.
`timescale 1ns / 100ps

module tb;
  import srtm_pkg::*;

  // The watchdog gives up after this many cycles with no request or response moving.
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_REQS = 1300;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_req = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_rsp;
  int    errors;
  int    pending;

  // Percentages of idle cycles for the sender and of stall cycles for the receiver.
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  // A long receiver hold-off is requested here and counted down in the stall process.
  logic  hold_go = 1'b0;
  logic  hold_taken = 1'b0;
  int    hold_left = 0;
  int    quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_region_table_merge dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp)
  );

  region_table_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_req(in_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_rsp(out_rsp),
    .errors(errors), .pending(pending)
  );

  // Receiver side: random stalls, except during the long hold-off, which keeps stall
  // high so the block fills its output and refuses requests.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: counts cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request, inserting random idle cycles first, and returns once it is taken.
  // Valid stays high after acceptance so back-to-back requests need no second assignment.
  task automatic offer(input cmd_t cmd, input logic [63:0] base, input logic [63:0] len,
                       input logic [31:0] kind, input logic [6:0] idx);
    in_t r;
    r.command = cmd;
    r.base = base;
    r.length = len;
    r.region_type = kind;
    r.read_index = idx;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (in_stall);
  endtask

  // Random request with clustered addresses so that overlapping chains form often,
  // mostly known types, and a minority of raw noise over every field bit.
  task automatic random_request();
    int          pick;
    logic [63:0] base;
    logic [63:0] len;
    logic [31:0] kind;
    logic [6:0]  idx;
    pick = $urandom_range(99);
    base = {32'd0, 20'($urandom_range(0, 255)), 12'd0};
    if ($urandom_range(9) == 0) base = {32'd0, 32'($urandom)};
    if ($urandom_range(19) == 0) base = {32'($urandom), 32'($urandom)};
    len = 64'($urandom_range(0, 32'h6000));
    case ($urandom_range(19))
      0: len = {32'($urandom), 32'($urandom)};
      1: len = {32'd0, 32'($urandom)};
      default: ;
    endcase
    kind = ($urandom_range(1) == 0) ? 32'd1 : 32'($urandom_range(1, CLASS_COUNT));
    if ($urandom_range(11) == 0) kind = 32'($urandom);
    idx = ($urandom_range(4) == 0) ? 7'($urandom) : 7'($urandom_range(0, 24));
    if (pick < 50)      offer(CMD_INSERT, base, len, kind, idx);
    else if (pick < 62) offer(CMD_MERGE, base, len, kind, idx);
    else if (pick < 96) offer(CMD_READ, base, len, kind, idx);
    else                offer(CMD_NONE, base, len, kind, idx);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: address and length extremes, the above-4G case, unknown types,
    // a three-entry overlapping chain, equal starts, every command and a bad index.
    offer(CMD_INSERT, 64'd0, 64'd0, 32'd1, 7'd0);
    offer(CMD_INSERT, 64'h0000_0000_ffff_ffff, 64'd1, 32'd2, 7'd0);
    offer(CMD_INSERT, 64'h0000_0001_0000_0000, 64'd16, 32'd1, 7'd0);
    offer(CMD_INSERT, '1, '1, '1, '1);
    offer(CMD_INSERT, 64'h8000, 64'h0000_0001_0000_0000, 32'd3, 7'd0);
    offer(CMD_INSERT, 64'h0000_0000_8000_0000, 64'h0000_0000_7fff_fffe, 32'd4, 7'd0);
    offer(CMD_INSERT, 64'h1000, 64'h1000, 32'd1, 7'd0);
    offer(CMD_INSERT, 64'h1800, 64'h2000, 32'd1, 7'd0);
    offer(CMD_INSERT, 64'h3000, 64'h0100, 32'd1, 7'd0);
    offer(CMD_INSERT, 64'h1000, 64'h0010, 32'd2, 7'd0);
    offer(CMD_INSERT, 64'h9000, 64'h10, 32'd0, 7'd0);
    offer(CMD_INSERT, 64'ha000, 64'h10, 32'd5, 7'd0);
    offer(CMD_INSERT, 64'hb000, 64'h10, 32'hffff_ffff, 7'd0);
    offer(CMD_READ, '0, '0, '0, 7'd3);
    offer(CMD_MERGE, '0, '0, '0, 7'd0);
    for (int i = 0; i < 6; i++) offer(CMD_READ, '1, '1, '1, 7'(i));
    offer(CMD_READ, '0, '0, '0, 7'd127);
    offer(CMD_NONE, '1, '1, '1, '1);
    offer(CMD_MERGE, '0, '0, '0, 7'd0);

    // Random part in four idling phases; the long hold-off falls in the first, and the
    // sender waits for all expected responses to drain before the third.
    for (int n = 0; n < RANDOM_REQS; n++) begin
      case (n)
        0:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        325: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        650: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        975: begin send_idle_pct = 17; recv_stall_pct = 17; end
        default: ;
      endcase
      if (n == 100) hold_go <= 1'b1;
      if (n == 650) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      random_request();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
